FILE: src/triangle_normal_tangent_unit_assert.svh
// Assertion macros shared by the triangle normal/tangent RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef TRIANGLE_NORMAL_TANGENT_UNIT_ASSERT_SVH
`define TRIANGLE_NORMAL_TANGENT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TNT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tnt check failed");
// next-cycle implication
`define TNT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tnt check failed");
`else
`define TNT_ASSERT_IMP(name, clk, rst, ante, cons)
`define TNT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: src/tnt_pkg.sv
// Shared types and width constants for the triangle normal/tangent unit.
// No dependencies.
`default_nettype none
package tnt_pkg;
   localparam int COORD_W     = 16;
   localparam int EDGE_W      = 17;
   localparam int PROD_W      = 34;
   localparam int CROSS_W     = 35;
   localparam int VEC_W       = 52;
   localparam int MAG_W       = 51;
   localparam int LEAD_W      = 6;
   localparam int NRM_W       = 30;
   localparam int SQ_W        = 60;
   localparam int SUM_W       = 62;
   localparam int ROOT_W      = 31;
   localparam int REM_W       = 35;
   localparam int ROOT_STEPS  = 4;
   localparam int ROOT_STAGES = 8;
   localparam int FRAC_SHIFT  = 14;
   localparam int NUM_W       = 46;
   localparam int QUO_W       = 15;
   localparam int DIV_STEPS   = 4;
   localparam int DIV_STAGES  = 4;
   localparam int OUT_W       = 16;
   localparam int ONE_Q14     = 16384;
   localparam int UNIT_LAT    = 5 + ROOT_STAGES + 1 + DIV_STAGES + 1;
   localparam int NE_W        = 33;
   localparam int DOT_W       = 35;
   localparam int NDOT_W      = 51;
   localparam int PROJ_SH     = 28;
   localparam int PRJ_W       = 52;
   localparam int P_W         = 36;
   localparam int TP_W        = 53;
   localparam int TAN_STAGES  = 6;

   typedef logic [2:0][VEC_W-1:0] vec_type;
   typedef logic [2:0][OUT_W-1:0] unit_type;

   typedef struct packed {
      logic [47:0] pos_a;
      logic [47:0] pos_b;
      logic [47:0] pos_c;
      logic [31:0] uv_a;
      logic [31:0] uv_b;
      logic [31:0] uv_c;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] normal_x;
      logic signed [OUT_W-1:0] normal_y;
      logic signed [OUT_W-1:0] normal_z;
      logic signed [OUT_W-1:0] tangent_x;
      logic signed [OUT_W-1:0] tangent_y;
      logic signed [OUT_W-1:0] tangent_z;
      logic                    normal_degenerate;
      logic                    tangent_degenerate;
   } rsp_type;

   typedef struct packed {
      logic [2:0][EDGE_W-1:0] e1;
      logic [2:0][EDGE_W-1:0] e2;
      logic [EDGE_W-1:0]      d1s;
      logic [EDGE_W-1:0]      d1t;
      logic [EDGE_W-1:0]      d2s;
      logic [EDGE_W-1:0]      d2t;
   } side_type;

   typedef struct packed {
      unit_type n;
      logic     deg;
   } norm_type;
endpackage
`default_nettype wire

FILE: src/tnt_front.sv
// Front end: edge and texture differences, then the face cross product.
// Depends on tnt_pkg.
`default_nettype none
module tnt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  tnt_pkg::req_type  in_req,
   output logic              out_valid,
   output tnt_pkg::vec_type  out_cross,
   output tnt_pkg::side_type out_side
);
   import tnt_pkg::*;

   logic                     v0_ff, v1_ff, v2_ff;
   logic signed [EDGE_W-1:0] e1_ff [3];
   logic signed [EDGE_W-1:0] e2_ff [3];
   logic signed [EDGE_W-1:0] e1_in [3];
   logic signed [EDGE_W-1:0] e2_in [3];
   side_type                 side0_in, side0_ff, side1_ff, side2_ff;
   logic signed [PROD_W-1:0] pa_ff [3];
   logic signed [PROD_W-1:0] pb_ff [3];
   vec_type                  cross_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = EDGE_W'($signed(in_req.pos_b[COORD_W*i +: COORD_W]))
                  - EDGE_W'($signed(in_req.pos_a[COORD_W*i +: COORD_W]));
         e2_in[i] = EDGE_W'($signed(in_req.pos_c[COORD_W*i +: COORD_W]))
                  - EDGE_W'($signed(in_req.pos_a[COORD_W*i +: COORD_W]));
         side0_in.e1[i] = e1_in[i];
         side0_in.e2[i] = e2_in[i];
      end
      side0_in.d1s = EDGE_W'($signed(in_req.uv_b[15:0]))  - EDGE_W'($signed(in_req.uv_a[15:0]));
      side0_in.d1t = EDGE_W'($signed(in_req.uv_b[31:16])) - EDGE_W'($signed(in_req.uv_a[31:16]));
      side0_in.d2s = EDGE_W'($signed(in_req.uv_c[15:0]))  - EDGE_W'($signed(in_req.uv_a[15:0]));
      side0_in.d2t = EDGE_W'($signed(in_req.uv_c[31:16])) - EDGE_W'($signed(in_req.uv_a[31:16]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      for (int i = 0; i < 3; i++) begin
         e1_ff[i] <= e1_in[i];
         e2_ff[i] <= e2_in[i];
      end
      side0_ff <= side0_in;
      // cross product partial terms
      pa_ff[0] <= PROD_W'(e1_ff[1]) * PROD_W'(e2_ff[2]);
      pb_ff[0] <= PROD_W'(e1_ff[2]) * PROD_W'(e2_ff[1]);
      pa_ff[1] <= PROD_W'(e1_ff[2]) * PROD_W'(e2_ff[0]);
      pb_ff[1] <= PROD_W'(e1_ff[0]) * PROD_W'(e2_ff[2]);
      pa_ff[2] <= PROD_W'(e1_ff[0]) * PROD_W'(e2_ff[1]);
      pb_ff[2] <= PROD_W'(e1_ff[1]) * PROD_W'(e2_ff[0]);
      side1_ff <= side0_ff;
      for (int i = 0; i < 3; i++) begin
         cross_ff[i] <= VEC_W'(CROSS_W'(pa_ff[i]) - CROSS_W'(pb_ff[i]));
      end
      side2_ff <= side1_ff;
   end

   assign out_valid = v2_ff;
   assign out_cross = cross_ff;
   assign out_side  = side2_ff;
endmodule
`default_nettype wire

FILE: src/tnt_isqrt.sv
// Pipelined integer square root, up to ROOT_STEPS (4) result bits per stage.
// Depends on tnt_pkg.
`default_nettype none
module tnt_isqrt (
   input  logic                       clock,
   input  logic [tnt_pkg::SUM_W-1:0]  rad,
   output logic [tnt_pkg::ROOT_W-1:0] root
);
   import tnt_pkg::*;

   logic [REM_W-1:0]  rem_ff  [ROOT_STAGES];
   logic [ROOT_W-1:0] root_ff [ROOT_STAGES];
   logic [SUM_W-1:0]  rad_ff  [ROOT_STAGES];

   for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
      logic [REM_W-1:0]  rem_s, rem_in;
      logic [ROOT_W-1:0] root_s, root_in;
      logic [SUM_W-1:0]  rad_s;

      if (k == 0) begin : g_first
         assign rem_s  = '0;
         assign root_s = '0;
         assign rad_s  = rad;
      end else begin : g_next
         assign rem_s  = rem_ff[k-1];
         assign root_s = root_ff[k-1];
         assign rad_s  = rad_ff[k-1];
      end

      always_comb begin
         logic [REM_W-1:0] trial;
         int               b;
         rem_in  = rem_s;
         root_in = root_s;
         trial   = '0;
         b       = 0;
         for (int j = 0; j < ROOT_STEPS; j++) begin
            b = ROOT_W - 1 - ROOT_STEPS * k - j;
            if (b >= 0) begin
               // bring down the next radicand bit pair, try 4*root+1
               rem_in = {rem_in[REM_W-3:0], rad_s[2*b +: 2]};
               trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
               if (rem_in >= trial) begin
                  rem_in  = rem_in - trial;
                  root_in = {root_in[ROOT_W-2:0], 1'b1};
               end else begin
                  root_in = {root_in[ROOT_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= rad_s;
      end
   end

   assign root = root_ff[ROOT_STAGES-1];
endmodule
`default_nettype wire

FILE: src/tnt_unitize.sv
// Vector normalizer: magnitude scaling, sum of squares, square root, and
// per-component restoring division to signed Q1.14. Depends on tnt_pkg, tnt_isqrt.
`default_nettype none
`include "triangle_normal_tangent_unit_assert.svh"
module tnt_unitize (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  tnt_pkg::vec_type  in_vec,
   output logic              out_valid,
   output tnt_pkg::unit_type out_vec,
   output logic              out_deg
);
   import tnt_pkg::*;

   // stage 1: magnitudes
   logic             v1_ff;
   logic [MAG_W-1:0] mag1_ff [3];
   logic [MAG_W-1:0] mag1_in [3];
   logic [2:0]       neg1_ff;
   // stage 2: leading one of the largest magnitude
   logic              v2_ff, zero2_ff;
   logic [LEAD_W-1:0] lead2_ff, lead2_in;
   logic [MAG_W-1:0]  mag2_ff [3];
   logic [MAG_W-1:0]  or2;
   logic [2:0]        neg2_ff;
   // stage 3: scaled into [2^29, 2^30)
   logic             v3_ff, zero3_ff;
   logic [NRM_W-1:0] m3_ff [3];
   logic [NRM_W-1:0] m3_in [3];
   logic [2:0]       neg3_ff;
   // stage 4: squares
   logic             v4_ff, zero4_ff;
   logic [SQ_W-1:0]  sq4_ff [3];
   logic [NRM_W-1:0] m4_ff [3];
   logic [2:0]       neg4_ff;
   // stage 5: sum of squares
   logic             v5_ff, zero5_ff;
   logic [SUM_W-1:0] sum5_ff;
   logic [NRM_W-1:0] m5_ff [3];
   logic [2:0]       neg5_ff;
   // alongside the root
   logic             vs_ff [ROOT_STAGES];
   logic             zs_ff [ROOT_STAGES];
   logic [2:0]       negs_ff [ROOT_STAGES];
   logic [NRM_W-1:0] ms_ff [ROOT_STAGES][3];
   logic [ROOT_W-1:0] root;
   // numerator stage
   logic              vn_ff, zn_ff;
   logic [2:0]        negn_ff;
   logic [NUM_W-1:0]  num_ff [3];
   logic [ROOT_W-1:0] den_ff;
   // division stages
   logic              dv_ff   [DIV_STAGES];
   logic              dz_ff   [DIV_STAGES];
   logic [2:0]        dneg_ff [DIV_STAGES];
   logic [ROOT_W-1:0] dden_ff [DIV_STAGES];
   logic [NUM_W-1:0]  dnum_ff [DIV_STAGES][3];
   logic [QUO_W-1:0]  dquo_ff [DIV_STAGES][3];
   // output
   logic     ov_ff, odeg_ff;
   unit_type ovec_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag1_in[i] = in_vec[i][VEC_W-1] ? MAG_W'(-$signed(in_vec[i])) : MAG_W'(in_vec[i]);
      end
      or2      = mag1_ff[0] | mag1_ff[1] | mag1_ff[2];
      lead2_in = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (or2[b]) lead2_in = LEAD_W'(b);
      end
      for (int i = 0; i < 3; i++) begin
         if (lead2_ff >= LEAD_W'(NRM_W - 1)) begin
            m3_in[i] = NRM_W'(mag2_ff[i] >> (lead2_ff - LEAD_W'(NRM_W - 1)));
         end else begin
            m3_in[i] = NRM_W'(mag2_ff[i] << (LEAD_W'(NRM_W - 1) - lead2_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      for (int i = 0; i < 3; i++) begin
         mag1_ff[i] <= mag1_in[i];
         neg1_ff[i] <= in_vec[i][VEC_W-1];
         mag2_ff[i] <= mag1_ff[i];
         m3_ff[i]   <= m3_in[i];
         sq4_ff[i]  <= SQ_W'(m3_ff[i]) * SQ_W'(m3_ff[i]);
         m4_ff[i]   <= m3_ff[i];
         m5_ff[i]   <= m4_ff[i];
      end
      neg2_ff  <= neg1_ff;
      lead2_ff <= lead2_in;
      zero2_ff <= (or2 == '0);
      neg3_ff  <= neg2_ff;
      zero3_ff <= zero2_ff;
      neg4_ff  <= neg3_ff;
      zero4_ff <= zero3_ff;
      neg5_ff  <= neg4_ff;
      zero5_ff <= zero4_ff;
      sum5_ff  <= SUM_W'(sq4_ff[0]) + SUM_W'(sq4_ff[1]) + SUM_W'(sq4_ff[2]);
   end

   tnt_isqrt u_isqrt (
      .clock (clock),
      .rad   (sum5_ff),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROOT_STAGES; k++) vs_ff[k] <= 1'b0;
         vn_ff <= 1'b0;
      end else begin
         vs_ff[0] <= v5_ff;
         for (int k = 1; k < ROOT_STAGES; k++) vs_ff[k] <= vs_ff[k-1];
         vn_ff <= vs_ff[ROOT_STAGES-1];
      end
      zs_ff[0]   <= zero5_ff;
      negs_ff[0] <= neg5_ff;
      for (int i = 0; i < 3; i++) ms_ff[0][i] <= m5_ff[i];
      for (int k = 1; k < ROOT_STAGES; k++) begin
         zs_ff[k]   <= zs_ff[k-1];
         negs_ff[k] <= negs_ff[k-1];
         for (int i = 0; i < 3; i++) ms_ff[k][i] <= ms_ff[k-1][i];
      end
      // rounded numerator: m * 2^14 + floor(L / 2)
      zn_ff   <= zs_ff[ROOT_STAGES-1];
      negn_ff <= negs_ff[ROOT_STAGES-1];
      den_ff  <= root;
      for (int i = 0; i < 3; i++) begin
         num_ff[i] <= NUM_W'({ms_ff[ROOT_STAGES-1][i], {FRAC_SHIFT{1'b0}}})
                    + NUM_W'(root >> 1);
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic              v_s, z_s;
      logic [2:0]        neg_s;
      logic [ROOT_W-1:0] den_s;
      logic [NUM_W-1:0]  num_s [3];
      logic [QUO_W-1:0]  quo_s [3];
      logic [NUM_W-1:0]  num_in [3];
      logic [QUO_W-1:0]  quo_in [3];

      if (k == 0) begin : g_first
         assign v_s   = vn_ff;
         assign z_s   = zn_ff;
         assign neg_s = negn_ff;
         assign den_s = den_ff;
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign num_s[i] = num_ff[i];
            assign quo_s[i] = '0;
         end
      end else begin : g_next
         assign v_s   = dv_ff[k-1];
         assign z_s   = dz_ff[k-1];
         assign neg_s = dneg_ff[k-1];
         assign den_s = dden_ff[k-1];
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign num_s[i] = dnum_ff[k-1][i];
            assign quo_s[i] = dquo_ff[k-1][i];
         end
      end

      always_comb begin
         logic [NUM_W-1:0] sub;
         int               b;
         sub = '0;
         b   = 0;
         for (int i = 0; i < 3; i++) begin
            num_in[i] = num_s[i];
            quo_in[i] = quo_s[i];
            for (int j = 0; j < DIV_STEPS; j++) begin
               b = QUO_W - 1 - DIV_STEPS * k - j;
               if (b >= 0) begin
                  sub = NUM_W'(den_s) << b;
                  if (num_in[i] >= sub) begin
                     num_in[i] = num_in[i] - sub;
                     quo_in[i][b] = 1'b1;
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_ff[k] <= 1'b0;
         else       dv_ff[k] <= v_s;
         dz_ff[k]   <= z_s;
         dneg_ff[k] <= neg_s;
         dden_ff[k] <= den_s;
         for (int i = 0; i < 3; i++) begin
            dnum_ff[k][i] <= num_in[i];
            dquo_ff[k][i] <= quo_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else       ov_ff <= dv_ff[DIV_STAGES-1];
      odeg_ff <= dz_ff[DIV_STAGES-1];
      for (int i = 0; i < 3; i++) begin
         if (dz_ff[DIV_STAGES-1]) begin
            ovec_ff[i] <= '0;
         end else if (dneg_ff[DIV_STAGES-1][i]) begin
            ovec_ff[i] <= OUT_W'(-$signed({1'b0, dquo_ff[DIV_STAGES-1][i]}));
         end else begin
            ovec_ff[i] <= OUT_W'({1'b0, dquo_ff[DIV_STAGES-1][i]});
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_vec   = ovec_ff;
   assign out_deg   = odeg_ff;

   `TNT_ASSERT_IMP(a_unit_range, clock, reset, out_valid, ($signed(out_vec[0]) >= -ONE_Q14 && $signed(out_vec[0]) <= ONE_Q14 && $signed(out_vec[1]) >= -ONE_Q14 && $signed(out_vec[1]) <= ONE_Q14 && $signed(out_vec[2]) >= -ONE_Q14 && $signed(out_vec[2]) <= ONE_Q14))
   `TNT_ASSERT_IMP(a_deg_zero, clock, reset, out_valid && out_deg, (out_vec == '0))
   `TNT_ASSERT_IMP(a_live_nonzero, clock, reset, out_valid && !out_deg, (out_vec != '0))
endmodule
`default_nettype wire

FILE: src/tnt_tangent.sv
// Tangent builder: edge projection onto the face plane, texture orientation
// flip, and the combined unnormalized tangent. Depends on tnt_pkg.
`default_nettype none
module tnt_tangent (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  tnt_pkg::norm_type in_norm,
   input  tnt_pkg::side_type in_side,
   output logic              out_valid,
   output tnt_pkg::vec_type  out_tan,
   output tnt_pkg::norm_type out_norm
);
   import tnt_pkg::*;

   logic     v_ff [TAN_STAGES];
   norm_type norm_ff [TAN_STAGES];

   // T1
   logic signed [NE_W-1:0]   pe1_ff [3];
   logic signed [NE_W-1:0]   pe2_ff [3];
   side_type                 side1_ff;
   // T2
   logic signed [DOT_W-1:0]  dot1_ff, dot2_ff;
   logic signed [EDGE_W-1:0] ds1_ff, ds2_ff;
   logic                     flip;
   logic [2:0][EDGE_W-1:0]   e1_2_ff, e2_2_ff;
   // T3
   logic signed [NDOT_W-1:0] nd1_ff [3];
   logic signed [NDOT_W-1:0] nd2_ff [3];
   logic [2:0][EDGE_W-1:0]   e1_3_ff, e2_3_ff;
   logic signed [EDGE_W-1:0] ds1_3_ff, ds2_3_ff;
   // T4
   logic signed [P_W-1:0]    p1_ff [3];
   logic signed [P_W-1:0]    p2_ff [3];
   logic signed [PRJ_W-1:0]  j1 [3];
   logic signed [PRJ_W-1:0]  j2 [3];
   logic signed [EDGE_W-1:0] ds1_4_ff, ds2_4_ff;
   // T5, T6
   logic signed [TP_W-1:0]   tp1_ff [3];
   logic signed [TP_W-1:0]   tp2_ff [3];
   vec_type                  tan_ff;

   // orientation test on texture differences, one bit wider so sums cannot wrap
   assign flip = ((EDGE_W+1)'($signed(side1_ff.d1t)) + (EDGE_W+1)'($signed(side1_ff.d2s)))
               > ((EDGE_W+1)'($signed(side1_ff.d1s)) + (EDGE_W+1)'($signed(side1_ff.d2t)));

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         j1[i] = ((PRJ_W'($signed(e1_3_ff[i])) <<< PROJ_SH) - PRJ_W'(nd1_ff[i])) >>> FRAC_SHIFT;
         j2[i] = ((PRJ_W'($signed(e2_3_ff[i])) <<< PROJ_SH) - PRJ_W'(nd2_ff[i])) >>> FRAC_SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAN_STAGES; k++) v_ff[k] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < TAN_STAGES; k++) v_ff[k] <= v_ff[k-1];
      end
      norm_ff[0] <= in_norm;
      for (int k = 1; k < TAN_STAGES; k++) norm_ff[k] <= norm_ff[k-1];

      for (int i = 0; i < 3; i++) begin
         pe1_ff[i] <= NE_W'($signed(in_norm.n[i])) * NE_W'($signed(in_side.e1[i]));
         pe2_ff[i] <= NE_W'($signed(in_norm.n[i])) * NE_W'($signed(in_side.e2[i]));
      end
      side1_ff <= in_side;

      dot1_ff <= DOT_W'(pe1_ff[0]) + DOT_W'(pe1_ff[1]) + DOT_W'(pe1_ff[2]);
      dot2_ff <= DOT_W'(pe2_ff[0]) + DOT_W'(pe2_ff[1]) + DOT_W'(pe2_ff[2]);
      ds1_ff  <= flip ? -$signed(side1_ff.d1s) : $signed(side1_ff.d1s);
      ds2_ff  <= flip ? -$signed(side1_ff.d2s) : $signed(side1_ff.d2s);
      e1_2_ff <= side1_ff.e1;
      e2_2_ff <= side1_ff.e2;

      for (int i = 0; i < 3; i++) begin
         nd1_ff[i] <= NDOT_W'($signed(norm_ff[1].n[i])) * NDOT_W'(dot1_ff);
         nd2_ff[i] <= NDOT_W'($signed(norm_ff[1].n[i])) * NDOT_W'(dot2_ff);
      end
      e1_3_ff  <= e1_2_ff;
      e2_3_ff  <= e2_2_ff;
      ds1_3_ff <= ds1_ff;
      ds2_3_ff <= ds2_ff;

      for (int i = 0; i < 3; i++) begin
         p1_ff[i] <= j1[i][P_W-1:0];
         p2_ff[i] <= j2[i][P_W-1:0];
      end
      ds1_4_ff <= ds1_3_ff;
      ds2_4_ff <= ds2_3_ff;

      for (int i = 0; i < 3; i++) begin
         tp1_ff[i] <= TP_W'(p1_ff[i]) * TP_W'(ds2_4_ff);
         tp2_ff[i] <= TP_W'(p2_ff[i]) * TP_W'(ds1_4_ff);
      end

      for (int i = 0; i < 3; i++) begin
         tan_ff[i] <= VEC_W'(tp1_ff[i] - tp2_ff[i]);
      end
   end

   assign out_valid = v_ff[TAN_STAGES-1];
   assign out_tan   = tan_ff;
   assign out_norm  = norm_ff[TAN_STAGES-1];
endmodule
`default_nettype wire

FILE: src/triangle_normal_tangent_unit.sv
// Triangle normal/tangent unit, top level.
// Depends on tnt_pkg, tnt_front, tnt_unitize, tnt_tangent.
//
// Usage:
//   One triangle per transaction on the request side: three Q8.8 corner
//   positions and three Q4.12 texture coordinates in req_data. A transaction
//   is taken on a rising edge with start high and busy low. busy is never
//   asserted; a new triangle may be issued every cycle.
//   Each result (unit normal, unit tangent, both Q1.14, and two degenerate
//   flags) appears on rsp_data for one cycle with rsp_strobe high.
//   The path from accept to strobe runs through 3 front-end stages, two
//   19-stage normalizers (8 of them for the square root, 4 for the
//   quotient lanes) and 6 tangent stages in between. Throughput is one
//   triangle per cycle; results come out in issue order.
//   Reset clears the valid bits of every stage, so no strobe follows reset
//   until a new triangle is taken; in-flight work is dropped.
//   The receiver cannot stall: results must be captured when strobed.
//   No configuration and no state is kept between triangles.
`default_nettype none
module triangle_normal_tangent_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tnt_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tnt_pkg::rsp_type rsp_data
);
   import tnt_pkg::*;

   logic     f_valid;
   vec_type  f_cross;
   side_type f_side;
   logic     n_valid, n_deg;
   unit_type n_vec;
   side_type side_dly_ff [UNIT_LAT];
   norm_type n_norm;
   logic     t_valid;
   vec_type  t_tan;
   norm_type t_norm;
   norm_type norm_dly_ff [UNIT_LAT];
   logic     u_valid, u_deg;
   unit_type u_vec;

   assign busy = 1'b0;

   tnt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_req    (req_data),
      .out_valid (f_valid),
      .out_cross (f_cross),
      .out_side  (f_side)
   );

   tnt_unitize u_norm_unit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_vec    (f_cross),
      .out_valid (n_valid),
      .out_vec   (n_vec),
      .out_deg   (n_deg)
   );

   // edges and texture deltas ride alongside the normal normalizer, the unit normal alongside the tangent one
   always_ff @(posedge clock) begin
      side_dly_ff[0] <= f_side;
      for (int k = 1; k < UNIT_LAT; k++) side_dly_ff[k] <= side_dly_ff[k-1];
      norm_dly_ff[0] <= t_norm;
      for (int k = 1; k < UNIT_LAT; k++) norm_dly_ff[k] <= norm_dly_ff[k-1];
   end

   assign n_norm.n   = n_vec;
   assign n_norm.deg = n_deg;

   tnt_tangent u_tangent (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n_valid),
      .in_norm   (n_norm),
      .in_side   (side_dly_ff[UNIT_LAT-1]),
      .out_valid (t_valid),
      .out_tan   (t_tan),
      .out_norm  (t_norm)
   );

   tnt_unitize u_tan_unit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t_valid),
      .in_vec    (t_tan),
      .out_valid (u_valid),
      .out_vec   (u_vec),
      .out_deg   (u_deg)
   );

   assign rsp_strobe                  = u_valid;
   assign rsp_data.normal_x           = norm_dly_ff[UNIT_LAT-1].n[0];
   assign rsp_data.normal_y           = norm_dly_ff[UNIT_LAT-1].n[1];
   assign rsp_data.normal_z           = norm_dly_ff[UNIT_LAT-1].n[2];
   assign rsp_data.tangent_x          = u_vec[0];
   assign rsp_data.tangent_y          = u_vec[1];
   assign rsp_data.tangent_z          = u_vec[2];
   assign rsp_data.normal_degenerate  = norm_dly_ff[UNIT_LAT-1].deg;
   assign rsp_data.tangent_degenerate = u_deg;
endmodule
`default_nettype wire
